@@ hdl/cswq_pkg.sv @@
// package for the counting semaphore with wait queue
// holds request and result types, status codes and default sizes
// no dependencies

package cswq_pkg;

	// default sizes handed to the top level parameters
	localparam int WAIT_DEPTH_DEF  = 16;
	localparam int COUNT_WIDTH_DEF = 16;

	// fixed field widths
	localparam int TASK_W    = 4;
	localparam int CFG_W     = 16;
	localparam int COUNT_OUT_W = 16;
	localparam int WAITERS_W = 5;

	// request command codes
	typedef enum logic {
		CMD_DOWN = 1'b0,
		CMD_UP   = 1'b1
	} cmd_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_BLOCKED  = 3'd1,
		ST_RELEASED = 3'd2,
		ST_WOKE     = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	// one request transaction
	typedef struct packed {
		cmd_t              command;
		logic [TASK_W-1:0] task_id;
	} req_t;

	// one result transaction
	typedef struct packed {
		status_t                status;
		logic [TASK_W-1:0]      woken_task;
		logic [COUNT_OUT_W-1:0] count_value;
		logic [WAITERS_W-1:0]   waiters;
	} rsp_t;

	// queue operation requested by the control logic
	typedef struct packed {
		logic push;
		logic pop;
	} q_op_t;

	// queue status seen by the control logic
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

@@ hdl/cswq_queue.sv @@
// fifo of waiting task numbers for the counting semaphore
// memory with registered read, head/tail pointers and occupancy
// depends on cswq_pkg

module cswq_queue #(
	parameter int WAIT_DEPTH = cswq_pkg::WAIT_DEPTH_DEF,
	parameter int PTR_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
	parameter int OCC_W      = $clog2(WAIT_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cswq_pkg::q_op_t             op,
	input  logic [cswq_pkg::TASK_W-1:0] push_task,
	output cswq_pkg::q_stat_t           stat,
	output logic [OCC_W-1:0]            occupancy,
	output logic [cswq_pkg::TASK_W-1:0] pop_task
);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WAIT_DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(WAIT_DEPTH);

	logic [cswq_pkg::TASK_W-1:0] mem [WAIT_DEPTH];
	logic [PTR_W-1:0]            head_q;
	logic [PTR_W-1:0]            tail_q;
	logic [OCC_W-1:0]            occ_q;
	logic [cswq_pkg::TASK_W-1:0] pop_task_q;

	// status flags
	assign stat.empty = (occ_q == '0);
	assign stat.full  = (occ_q == OCC_FULL);
	assign occupancy  = occ_q;
	assign pop_task   = pop_task_q;

	// storage: write at tail on push, read at head every cycle
	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[tail_q] <= push_task;
		end
		pop_task_q <= mem[head_q];
	end

	// pointers and occupancy, wrapping at the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else begin
			if (op.push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
			end
			if (op.pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
			end
			if (op.push && !op.pop) begin
				occ_q <= occ_q + 1'b1;
			end else if (op.pop && !op.push) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/counting_semaphore_wait_queue.sv @@
// Counting semaphore with a FIFO of waiting task numbers. A request is
// accepted on any cycle with start high and busy low; busy never rises,
// so a request may be issued every cycle. Each request gives exactly one
// result, strobed by result_valid for one cycle, in the cycle after the
// request: the count and queue pointers are updated in that accept cycle
// and the woken task number comes from the registered read of the
// wait queue memory at the head pointer. The receiver cannot
// stall results and must take each one on its strobe. A write on the
// configuration channel (always ready) reloads the count and leaves the
// queue untouched; write it only while no request is in flight.
// depends on cswq_pkg and cswq_queue

module counting_semaphore_wait_queue #(
	parameter int WAIT_DEPTH  = cswq_pkg::WAIT_DEPTH_DEF,
	parameter int COUNT_WIDTH = cswq_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  cswq_pkg::req_t             request,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cswq_pkg::CFG_W-1:0] cfg_data,
	output logic                       result_valid,
	output cswq_pkg::rsp_t             result
);

	localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int OCC_W = $clog2(WAIT_DEPTH + 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic                        accept;
	logic                        cfg_write;
	logic [COUNT_WIDTH-1:0]      count_q;
	logic [COUNT_WIDTH-1:0]      count_next;
	cswq_pkg::status_t           status_next;
	cswq_pkg::status_t           status_q;
	logic                        result_valid_q;
	cswq_pkg::q_op_t             q_op;
	cswq_pkg::q_stat_t           q_stat;
	logic [OCC_W-1:0]            occupancy;
	logic [cswq_pkg::TASK_W-1:0] pop_task;
	logic [31:0]                 cfg_wide;
	logic [31:0]                 count_wide;
	logic [31:0]                 occ_wide;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cfg_write = cfg_valid && cfg_ready;

	// wait queue
	cswq_queue #(
		.WAIT_DEPTH (WAIT_DEPTH),
		.PTR_W      (PTR_W),
		.OCC_W      (OCC_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (q_op),
		.push_task (request.task_id),
		.stat      (q_stat),
		.occupancy (occupancy),
		.pop_task  (pop_task)
	);

	// request decision: count update, queue operation and status
	always_comb begin
		count_next  = count_q;
		q_op        = '0;
		status_next = cswq_pkg::ST_GRANTED;
		case (request.command)
			cswq_pkg::CMD_DOWN: begin
				if (count_q != '0) begin
					count_next  = count_q - 1'b1;
					status_next = cswq_pkg::ST_GRANTED;
				end else if (!q_stat.full) begin
					q_op.push   = accept;
					status_next = cswq_pkg::ST_BLOCKED;
				end else begin
					status_next = cswq_pkg::ST_FULL;
				end
			end
			cswq_pkg::CMD_UP: begin
				if (count_q != COUNT_MAX) begin
					count_next = count_q + 1'b1;
				end
				if (!q_stat.empty) begin
					q_op.pop    = accept;
					status_next = cswq_pkg::ST_WOKE;
				end else begin
					status_next = cswq_pkg::ST_RELEASED;
				end
			end
			default: begin
				status_next = cswq_pkg::ST_GRANTED;
			end
		endcase
	end

	// count register, reloaded from the configuration channel
	assign cfg_wide = 32'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end else if (cfg_write) begin
			count_q <= cfg_wide[COUNT_WIDTH-1:0];
		end
	end

	// result strobe and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			status_q       <= cswq_pkg::ST_GRANTED;
		end else begin
			result_valid_q <= accept;
			if (accept) begin
				status_q <= status_next;
			end
		end
	end

	// result assembly from the post-request state
	assign count_wide = 32'(count_q);
	assign occ_wide   = 32'(occupancy);

	assign result_valid       = result_valid_q;
	assign result.status      = status_q;
	assign result.woken_task  = (status_q == cswq_pkg::ST_WOKE) ? pop_task : '0;
	assign result.count_value = count_wide[cswq_pkg::COUNT_OUT_W-1:0];
	assign result.waiters     = occ_wide[cswq_pkg::WAITERS_W-1:0];

	// every accepted request gives a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted request without result strobe");

	// a woken waiter takes one entry off the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && q_op.pop |=> occupancy == $past(occupancy) - 1'b1)
		else $error("wake did not shrink the queue");

	// a rejected down only happens with zero count and a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == cswq_pkg::ST_FULL |->
		count_q == '0 && q_stat.full)
		else $error("full rejection with count or room left");

	// blocked down never changes the count
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && q_op.push |=> count_q == '0)
		else $error("blocked request changed the count");

endmodule

@@ tb/sv/tb_counting_semaphore_wait_queue.sv @@
// testbench for the counting semaphore with fifo wait queue
// predicts every result from its own copy of count and queue, checks it field by field
// depends on cswq_pkg and counting_semaphore_wait_queue
`timescale 1ns / 100ps

module tb_counting_semaphore_wait_queue;
	import cswq_pkg::*;

	localparam int DEPTH = WAIT_DEPTH_DEF;
	localparam int CNT_W = COUNT_WIDTH_DEF;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	bit clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic result_valid;
	rsp_t result;

	// requests waiting to be driven and results predicted but not yet seen
	req_t pending_reqs[$];
	rsp_t expected_rsps[$];

	// predicted semaphore state
	logic [CNT_W-1:0] sem_count = '0;
	logic [TASK_W-1:0] waitq [DEPTH];
	int wq_head = 0;
	int wq_tail = 0;
	int wq_fill = 0;

	int idle_pct = 8;
	int mismatch_count = 0;
	bit last_accept = 1'b0;

	counting_semaphore_wait_queue #(
		.WAIT_DEPTH(DEPTH),
		.COUNT_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// apply one down or up to the predicted state and return its result
	task automatic apply_request(input req_t rq, output rsp_t rs);
		rs = '0;
		if (rq.command == CMD_DOWN) begin
			if (sem_count != '0) begin
				sem_count = sem_count - 1'b1;
				rs.status = ST_GRANTED;
			end else if (wq_fill < DEPTH) begin
				waitq[wq_tail] = rq.task_id;
				wq_tail = (wq_tail + 1) % DEPTH;
				wq_fill++;
				rs.status = ST_BLOCKED;
			end else begin
				rs.status = ST_FULL;
			end
		end else begin
			// count saturates, a waiter is still woken
			if (sem_count != CNT_MAX)
				sem_count = sem_count + 1'b1;
			if (wq_fill > 0) begin
				rs.woken_task = waitq[wq_head];
				wq_head = (wq_head + 1) % DEPTH;
				wq_fill--;
				rs.status = ST_WOKE;
			end else begin
				rs.status = ST_RELEASED;
			end
		end
		rs.count_value = COUNT_OUT_W'(sem_count);
		rs.waiters = WAITERS_W'(wq_fill);
	endtask

	// driver: hold an offered request until taken, idle at random
	always @(negedge clk) begin
		if (!(start && !last_accept)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				request <= pending_reqs[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check strobed results, then predict accepted transactions
	always @(posedge clk) begin : monitor
		rsp_t want;
		rsp_t pred;
		last_accept = 1'b0;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_rsps.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result status=%0d woken=%0d count=%0d waiters=%0d",
							$realtime, result.status, result.woken_task,
							result.count_value, result.waiters);
				end else begin
					want = expected_rsps.pop_front();
					if (result.status !== want.status || result.woken_task !== want.woken_task ||
					    result.count_value !== want.count_value ||
					    result.waiters !== want.waiters) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch exp status=%0d woken=%0d count=%0d waiters=%0d, got status=%0d woken=%0d count=%0d waiters=%0d",
								$realtime, want.status, want.woken_task, want.count_value,
								want.waiters, result.status, result.woken_task,
								result.count_value, result.waiters);
					end
				end
			end
			// register write reloads the count only, queue is kept
			if (cfg_valid && cfg_ready)
				sem_count = CNT_W'(cfg_data);
			if (start && !busy) begin
				apply_request(pending_reqs.pop_front(), pred);
				expected_rsps.push_back(pred);
				last_accept = 1'b1;
			end
		end
	end

	task automatic queue_req(input cmd_t c, input int t);
		req_t r;
		r.command = c;
		r.task_id = TASK_W'(t);
		pending_reqs.push_back(r);
	endtask

	// wait until every request is taken and every result has been seen
	task automatic wait_idle();
		@(negedge clk);
		while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	task automatic load_count(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// bursts of downs or ups with random task numbers, some single noise items
	task automatic run_phase(input logic [CFG_W-1:0] cfg, input int down_pct,
			input int n, input int idle);
		int made;
		int len;
		cmd_t dir;
		made = 0;
		load_count(cfg);
		idle_pct = idle;
		while (made < n) begin
			len = $urandom_range(20, 1);
			dir = ($urandom_range(99) < down_pct) ? CMD_DOWN : CMD_UP;
			for (int j = 0; j < len && made < n; j++) begin
				if ($urandom_range(9) == 0)
					queue_req(cmd_t'($urandom_range(1)), $urandom_range(15));
				else
					queue_req(dir, $urandom_range(15));
				made++;
			end
		end
		wait_idle();
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: release with no waiter, grant, block, wake
		idle_pct = 8;
		queue_req(CMD_UP, 3);
		queue_req(CMD_DOWN, 9);
		queue_req(CMD_DOWN, 15);
		queue_req(CMD_UP, 1);
		queue_req(CMD_DOWN, 2);
		// fill the queue, last waiter a duplicate, then one rejected
		for (int i = 0; i < 15; i++)
			queue_req(CMD_DOWN, i);
		queue_req(CMD_DOWN, 0);
		queue_req(CMD_DOWN, 7);
		queue_req(CMD_UP, 4);
		wait_idle();
		// reload while tasks wait, then saturate on up
		load_count('1);
		queue_req(CMD_UP, 6);
		queue_req(CMD_DOWN, 10);
		wait_idle();

		// random phases over several count settings
		run_phase('0, 70, 200, 8);
		run_phase('1, 30, 100, 8);
		run_phase(16'd3, 50, 200, 73);
		run_phase(CFG_W'($urandom_range(65535)), 60, 150, 73);
		run_phase(16'd1, 80, 200, 0);
		run_phase(CFG_W'($urandom_range(20)), 40, 300, 0);

		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && expected_rsps.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run time limit
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
